// ===== hw/rtl/image_patch_source_address_unit_defines.svh =====
// assertion macros for the patch source address unit checker
// needs clk and rst_n in scope where a macro is used
`ifndef IMAGE_PATCH_SOURCE_ADDRESS_UNIT_DEFINES_SVH
`define IMAGE_PATCH_SOURCE_ADDRESS_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define IPSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define IPSA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ipsa_pkg.sv =====
// shared types and constants for the patch source address unit
// no dependencies
package ipsa_pkg;

    localparam int SIZE_W  = 13;
    localparam int BYTE_W  = 8;
    localparam int PAD_W   = 16;
    localparam int INDEX_W = 56;
    localparam int ADDR_W  = 5;
    localparam int REG_W   = 3;

    // register indexes, byte address is 4 * index
    localparam logic [REG_W-1:0] REG_IN_HEIGHT     = 3'd0;
    localparam logic [REG_W-1:0] REG_IN_WIDTH      = 3'd1;
    localparam logic [REG_W-1:0] REG_CHANNELS      = 3'd2;
    localparam logic [REG_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
    localparam logic [REG_W-1:0] REG_KERNEL_WIDTH  = 3'd4;
    localparam logic [REG_W-1:0] REG_STRIDE_PAIR   = 3'd5;
    localparam logic [REG_W-1:0] REG_RATE_PAIR     = 3'd6;
    localparam logic [REG_W-1:0] REG_PAD_MODE      = 3'd7;

    // auto-pad modes, code 3 behaves as valid
    localparam logic [1:0] PAD_VALID      = 2'd0;
    localparam logic [1:0] PAD_SAME_UPPER = 2'd1;
    localparam logic [1:0] PAD_SAME_LOWER = 2'd2;

    typedef struct packed {
        logic [7:0]  batch;
        logic [7:0]  kernel_row;
        logic [7:0]  kernel_col;
        logic [11:0] channel;
        logic [11:0] out_row;
        logic [11:0] out_col;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] source_index;
        logic               is_padding;
    } result_t;

    // one image axis for the pad derivation; all but mode already >= 1
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [BYTE_W-1:0] stride;
        logic [BYTE_W-1:0] kernel;
        logic [BYTE_W-1:0] rate;
        logic [1:0]        mode;
    } pad_side_t;

endpackage

// ===== hw/rtl/ipsa_pad_calc.sv =====
// derives the leading pad of one axis from size, stride, kernel and dilation
// depends on ipsa_pkg
module ipsa_pad_calc
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  ipsa_pkg::pad_side_t         side,
    output logic                        busy,
    output logic [ipsa_pkg::PAD_W-1:0]  pad
);

    localparam int CNT_W = $clog2(ipsa_pkg::SIZE_W + 1);

    logic                          busy_reg, busy_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [ipsa_pkg::BYTE_W-1:0]   rem_reg, rem_next;
    logic [ipsa_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [ipsa_pkg::BYTE_W-1:0]   div_reg, div_next;
    logic [ipsa_pkg::PAD_W-1:0]    ext_reg, ext_next;
    logic                          lower_reg, lower_next;
    logic                          same_reg, same_next;
    logic [ipsa_pkg::PAD_W-1:0]    pad_reg, pad_next;

    logic [ipsa_pkg::BYTE_W:0]     trial;
    logic [ipsa_pkg::BYTE_W-1:0]   tail;
    logic [ipsa_pkg::PAD_W+1:0]    total;
    logic [ipsa_pkg::PAD_W+1:0]    total_up;

    // remainder of size by stride, one bit a cycle
    assign trial = {rem_reg, size_reg[ipsa_pkg::SIZE_W-1]};
    // total = extent - (rem == 0 ? stride : rem)
    assign tail     = (rem_reg == '0) ? div_reg : rem_reg;
    assign total    = {2'b00, ext_reg} - {10'd0, tail};
    assign total_up = total + 18'd1;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        size_next  = size_reg;
        div_next   = div_reg;
        ext_next   = ext_reg;
        lower_next = lower_reg;
        same_next  = same_reg;
        pad_next   = pad_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(ipsa_pkg::SIZE_W);
            rem_next   = '0;
            size_next  = side.size;
            div_next   = side.stride;
            ext_next   = 16'(side.kernel)
                       + 16'(side.rate - 8'd1) * 16'(side.kernel - 8'd1);
            lower_next = (side.mode == ipsa_pkg::PAD_SAME_LOWER);
            same_next  = (side.mode == ipsa_pkg::PAD_SAME_UPPER)
                      || (side.mode == ipsa_pkg::PAD_SAME_LOWER);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next  = cnt_reg - CNT_W'(1);
                size_next = {size_reg[ipsa_pkg::SIZE_W-2:0], 1'b0};
                if (trial >= {1'b0, div_reg})
                begin
                    rem_next = ipsa_pkg::BYTE_W'(trial - {1'b0, div_reg});
                end
                else
                begin
                    rem_next = trial[ipsa_pkg::BYTE_W-1:0];
                end
            end
            else
            begin
                busy_next = 1'b0;
                // total never reaches extent, so only its sign and a zero total matter
                if (!same_reg || total[ipsa_pkg::PAD_W+1] || total == '0)
                begin
                    pad_next = '0;
                end
                else if (lower_reg)
                begin
                    pad_next = total_up[ipsa_pkg::PAD_W:1];
                end
                else
                begin
                    pad_next = total[ipsa_pkg::PAD_W:1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            pad_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            pad_reg  <= pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        size_reg  <= size_next;
        div_reg   <= div_next;
        ext_reg   <= ext_next;
        lower_reg <= lower_next;
        same_reg  <= same_next;
    end

    assign busy = busy_reg;
    assign pad  = pad_reg;

endmodule

// ===== hw/rtl/image_patch_source_address_unit.sv =====
// top level of the patch source address unit (im2col with dilation)
// depends on ipsa_pkg and ipsa_pad_calc
//
//  channel   signals                                      direction
//  item      item_valid, item_ready, item                 in
//  result    result_valid, result_ready, result           out
//  config    psel, penable, pwrite, paddr, pwdata,
//            prdata, pready                               in / out
//
// one beat per cycle sustained unless results stall or a pad derivation runs
// the address pipeline is four register stages: products, row and column,
// bounds check with the channel-row product, final multiply into the index
// a config write closes the item side while the two remainder
// loops re-derive top and left padding, one quotient bit a cycle
// reset clears registers to their documented values and empties the pipe
// each stage holds under back-pressure and takes a new beat into any bubble
module image_patch_source_address_unit
#(
    parameter int MAX_SIDE     = 4096,
    parameter int MAX_CHANNELS = 4096,
    parameter int MAX_BATCH    = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  ipsa_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output ipsa_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipsa_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // saturation limits, clipped to what the register widths can hold
    localparam int SIDE_LIM  = (MAX_SIDE < 8191) ? MAX_SIDE : 8191;
    localparam int CH_LIM    = (MAX_CHANNELS < 8191) ? MAX_CHANNELS : 8191;
    localparam int BATCH_LIM = (MAX_BATCH - 1 < 255) ? MAX_BATCH - 1 : 255;
    localparam logic [12:0] SIDE_CAP  = 13'(SIDE_LIM);
    localparam logic [12:0] CH_CAP    = 13'(CH_LIM);
    localparam logic [7:0]  BATCH_CAP = 8'(BATCH_LIM);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [12:0] in_height_reg, in_width_reg, channels_reg;
    logic [7:0]  kernel_height_reg, kernel_width_reg;
    logic [15:0] stride_pair_reg, rate_pair_reg;
    logic [1:0]  pad_mode_reg;
    logic        start_reg;

    logic                        cfg_wr;
    logic [ipsa_pkg::REG_W-1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ipsa_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg     <= 13'd1;
            in_width_reg      <= 13'd1;
            channels_reg      <= 13'd1;
            kernel_height_reg <= 8'd1;
            kernel_width_reg  <= 8'd1;
            stride_pair_reg   <= 16'd257;
            rate_pair_reg     <= 16'd257;
            pad_mode_reg      <= ipsa_pkg::PAD_VALID;
            start_reg         <= 1'b0;
        end
        else
        begin
            // any write kicks off a fresh pad derivation next cycle
            start_reg <= cfg_wr;
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    ipsa_pkg::REG_IN_HEIGHT:     in_height_reg     <= pwdata[12:0];
                    ipsa_pkg::REG_IN_WIDTH:      in_width_reg      <= pwdata[12:0];
                    ipsa_pkg::REG_CHANNELS:      channels_reg      <= pwdata[12:0];
                    ipsa_pkg::REG_KERNEL_HEIGHT: kernel_height_reg <= pwdata[7:0];
                    ipsa_pkg::REG_KERNEL_WIDTH:  kernel_width_reg  <= pwdata[7:0];
                    ipsa_pkg::REG_STRIDE_PAIR:   stride_pair_reg   <= pwdata[15:0];
                    ipsa_pkg::REG_RATE_PAIR:     rate_pair_reg     <= pwdata[15:0];
                    ipsa_pkg::REG_PAD_MODE:      pad_mode_reg      <= pwdata[1:0];
                endcase
            end
        end
    end

    // read back
    always_comb
    begin
        unique case (cfg_idx)
            ipsa_pkg::REG_IN_HEIGHT:     prdata = {19'd0, in_height_reg};
            ipsa_pkg::REG_IN_WIDTH:      prdata = {19'd0, in_width_reg};
            ipsa_pkg::REG_CHANNELS:      prdata = {19'd0, channels_reg};
            ipsa_pkg::REG_KERNEL_HEIGHT: prdata = {24'd0, kernel_height_reg};
            ipsa_pkg::REG_KERNEL_WIDTH:  prdata = {24'd0, kernel_width_reg};
            ipsa_pkg::REG_STRIDE_PAIR:   prdata = {16'd0, stride_pair_reg};
            ipsa_pkg::REG_RATE_PAIR:     prdata = {16'd0, rate_pair_reg};
            ipsa_pkg::REG_PAD_MODE:      prdata = {30'd0, pad_mode_reg};
        endcase
    end

    // ---------------------------------------------------------------
    // effective sizes: zero reads as one, sides and channels saturate
    // ---------------------------------------------------------------
    logic [12:0] ih, iw, ic;
    logic [7:0]  kh, kw, sh, sw, rh, rw;

    assign ih = (in_height_reg == '0) ? 13'd1
              : ((in_height_reg > SIDE_CAP) ? SIDE_CAP : in_height_reg);
    assign iw = (in_width_reg == '0) ? 13'd1
              : ((in_width_reg > SIDE_CAP) ? SIDE_CAP : in_width_reg);
    assign ic = (channels_reg == '0) ? 13'd1
              : ((channels_reg > CH_CAP) ? CH_CAP : channels_reg);
    assign kh = (kernel_height_reg == '0) ? 8'd1 : kernel_height_reg;
    assign kw = (kernel_width_reg == '0) ? 8'd1 : kernel_width_reg;
    assign sh = (stride_pair_reg[15:8] == '0) ? 8'd1 : stride_pair_reg[15:8];
    assign sw = (stride_pair_reg[7:0] == '0) ? 8'd1 : stride_pair_reg[7:0];
    assign rh = (rate_pair_reg[15:8] == '0) ? 8'd1 : rate_pair_reg[15:8];
    assign rw = (rate_pair_reg[7:0] == '0) ? 8'd1 : rate_pair_reg[7:0];

    // ---------------------------------------------------------------
    // pad derivation, one remainder loop per axis
    // ---------------------------------------------------------------
    ipsa_pkg::pad_side_t          top_side, left_side;
    logic                         top_busy, left_busy;
    logic [ipsa_pkg::PAD_W-1:0]   pad_top, pad_left;

    assign top_side  = '{size: ih, stride: sh, kernel: kh, rate: rh, mode: pad_mode_reg};
    assign left_side = '{size: iw, stride: sw, kernel: kw, rate: rw, mode: pad_mode_reg};

    ipsa_pad_calc u_pad_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .side  (top_side),
        .busy  (top_busy),
        .pad   (pad_top)
    );

    ipsa_pad_calc u_pad_left
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .side  (left_side),
        .busy  (left_busy),
        .pad   (pad_left)
    );

    // ---------------------------------------------------------------
    // address pipeline
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // each stage loads when empty or when the one after it moves
    assign en4 = !v4_reg || result_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign item_ready = en1 && !start_reg && !top_busy && !left_busy;

    // stage 1: the four offset products and batch-channel plane
    logic [15:0] rk1_reg, ck1_reg;
    logic [19:0] ro1_reg, co1_reg;
    logic [20:0] bc1_reg;
    logic [7:0]  b_sat;

    assign b_sat = (item.batch > BATCH_CAP) ? BATCH_CAP : item.batch;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            rk1_reg <= 16'(item.kernel_row) * 16'(rh);
            ck1_reg <= 16'(item.kernel_col) * 16'(rw);
            ro1_reg <= 20'(item.out_row) * 20'(sh);
            co1_reg <= 20'(item.out_col) * 20'(sw);
            bc1_reg <= 21'(b_sat) * 21'(ic) + 21'(item.channel);
        end
    end

    // stage 2: source row and column, two's complement in 22 bits
    logic [21:0] row2_reg, col2_reg;
    logic [20:0] bc2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            row2_reg <= 22'(rk1_reg) + 22'(ro1_reg) - 22'(pad_top);
            col2_reg <= 22'(ck1_reg) + 22'(co1_reg) - 22'(pad_left);
            bc2_reg  <= bc1_reg;
        end
    end

    // stage 3: bounds check, plane times height plus row
    logic        pad3_reg;
    logic [33:0] bcr3_reg;
    logic [12:0] col3_reg;
    logic        row_out, col_out;

    assign row_out = row2_reg[21] || (row2_reg[20:0] >= 21'(ih));
    assign col_out = col2_reg[21] || (col2_reg[20:0] >= 21'(iw));

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            pad3_reg <= row_out || col_out;
            bcr3_reg <= 34'(bc2_reg) * 34'(ih) + 34'(row2_reg[12:0]);
            col3_reg <= col2_reg[12:0];
        end
    end

    // stage 4: output register, padding reads as index zero
    ipsa_pkg::result_t res4_reg;
    logic [46:0]       idx4;

    assign idx4 = 47'(bcr3_reg) * 47'(iw) + 47'(col3_reg);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            res4_reg.is_padding   <= pad3_reg;
            res4_reg.source_index <= pad3_reg ? '0 : ipsa_pkg::INDEX_W'(idx4);
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= item_valid && item_ready;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign result_valid = v4_reg;
    assign result       = res4_reg;

endmodule

// ===== hw/rtl/ipsa_checker.sv =====
// port-level checks for the patch source address unit, bound to the top level
// depends on ipsa_pkg and image_patch_source_address_unit_defines.svh
`include "image_patch_source_address_unit_defines.svh"

module ipsa_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_ready,
    input  logic                result_valid,
    input  logic                result_ready,
    input  ipsa_pkg::result_t   result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite
);

    // a padding beat always carries index zero
    `IPSA_ASSERT_NOW(a_pad_zero, result_valid && result.is_padding, result.source_index == '0, "padding beat with nonzero index")

    // a stalled result beat holds
    `IPSA_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

    // a register write closes the item side while pads are re-derived
    `IPSA_ASSERT_NXT(a_cfg_block, psel && penable && pwrite, !item_ready ##1 !item_ready, "item beat taken during pad derivation")

endmodule

bind image_patch_source_address_unit ipsa_checker u_ipsa_checker (.*);

// ===== sim/image_patch_source_address_unit_test.sv =====
// self-checking bench for the patch source address unit: item and result streams plus apb setup
// depends on ipsa_pkg and image_patch_source_address_unit, nothing else
`timescale 1ns / 1ps

module image_patch_source_address_unit_test;

    localparam int MAX_SIDE        = 4096;
    localparam int MAX_CHANNELS    = 4096;
    localparam int MAX_BATCH       = 256;
    localparam int BYTE_MAX        = 255;
    localparam int REG_COUNT       = 8;
    localparam int IDLE_PERCENT    = 7;
    localparam int DRAIN_CYCLES    = 8;
    localparam int STALL_LIMIT     = 3000;
    localparam int RANDOM_PHASES   = 7;
    localparam int BEATS_PER_PHASE = 64;
    localparam int QUIET_PHASE     = 3;

    // the package names three modes; the fourth code must fall back to valid
    localparam logic [1:0] PAD_UNUSED = 2'd3;

    // register sets used by the directed table
    typedef enum int {
        CFG_RESET,
        CFG_SAME_UPPER,
        CFG_SAME_LOWER,
        CFG_LARGEST,
        CFG_ZEROS,
        CFG_OVERSIZED
    } directed_cfg_e;

    typedef struct {
        directed_cfg_e       setting;
        ipsa_pkg::item_t     beat;
        bit                  typed;
        ipsa_pkg::result_t   want;
    } directed_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        item_valid;
    logic                        item_ready;
    ipsa_pkg::item_t             item;
    logic                        result_valid;
    logic                        result_ready = 1'b0;
    ipsa_pkg::result_t           result;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ipsa_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    // mirror of the register file and of the derived top and left padding
    logic [31:0]   cfg_shadow [REG_COUNT];
    logic [31:0]   pending_cfg [REG_COUNT];
    longint        pad_top;
    longint        pad_left;

    ipsa_pkg::result_t awaited_addresses [$];
    directed_row_t     directed_q [$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    bit  steady = 1'b0;

    image_patch_source_address_unit
    #(
        .MAX_SIDE     (MAX_SIDE),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_BATCH    (MAX_BATCH)
    )
    DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // address arithmetic of the block
    // ------------------------------------------------------------------

    // zero counts as one, anything above the cap saturates
    function automatic longint fit_range(input longint v, input longint cap);
        if (v == 0)
            return 1;
        if (v > cap)
            return cap;
        return v;
    endfunction

    // leading pad of one axis for the same modes
    function automatic longint edge_pad(input longint size, input longint k,
                                        input longint stride, input longint rate,
                                        input logic [1:0] mode);
        longint extent;
        longint total;
        extent = k + (rate - 1) * (k - 1);
        total  = ((size + stride - 1) / stride - 1) * stride + extent - size;
        // only a total strictly inside (0, extent) produces padding
        if (total <= 0 || total >= extent)
            return 0;
        // lower mode rounds the half up, upper mode rounds it down
        if (mode == ipsa_pkg::PAD_SAME_LOWER)
            return (total + (total & 1)) / 2;
        return total / 2;
    endfunction

    // any register write re-derives both pads
    function automatic void refresh_pads();
        logic [1:0] mode;
        mode = cfg_shadow[ipsa_pkg::REG_PAD_MODE][1:0];
        if (mode == ipsa_pkg::PAD_SAME_UPPER || mode == ipsa_pkg::PAD_SAME_LOWER)
        begin
            pad_top = edge_pad(fit_range(cfg_shadow[ipsa_pkg::REG_IN_HEIGHT], MAX_SIDE),
                               fit_range(cfg_shadow[ipsa_pkg::REG_KERNEL_HEIGHT], BYTE_MAX),
                               fit_range(cfg_shadow[ipsa_pkg::REG_STRIDE_PAIR][15:8], BYTE_MAX),
                               fit_range(cfg_shadow[ipsa_pkg::REG_RATE_PAIR][15:8], BYTE_MAX),
                               mode) & 64'hFFFF;
            pad_left = edge_pad(fit_range(cfg_shadow[ipsa_pkg::REG_IN_WIDTH], MAX_SIDE),
                                fit_range(cfg_shadow[ipsa_pkg::REG_KERNEL_WIDTH], BYTE_MAX),
                                fit_range(cfg_shadow[ipsa_pkg::REG_STRIDE_PAIR][7:0], BYTE_MAX),
                                fit_range(cfg_shadow[ipsa_pkg::REG_RATE_PAIR][7:0], BYTE_MAX),
                                mode) & 64'hFFFF;
        end
        else
        begin
            // valid and the unused code give no padding
            pad_top  = 0;
            pad_left = 0;
        end
    endfunction

    // nchw source index of one output element, or the padding flag
    function automatic ipsa_pkg::result_t source_address_of(input ipsa_pkg::item_t beat);
        longint            ih, iw, ic, sh, sw, rh, rw;
        longint            b, row, col, idx;
        ipsa_pkg::result_t res;
        ih = fit_range(cfg_shadow[ipsa_pkg::REG_IN_HEIGHT], MAX_SIDE);
        iw = fit_range(cfg_shadow[ipsa_pkg::REG_IN_WIDTH], MAX_SIDE);
        ic = fit_range(cfg_shadow[ipsa_pkg::REG_CHANNELS], MAX_CHANNELS);
        sh = fit_range(cfg_shadow[ipsa_pkg::REG_STRIDE_PAIR][15:8], BYTE_MAX);
        sw = fit_range(cfg_shadow[ipsa_pkg::REG_STRIDE_PAIR][7:0], BYTE_MAX);
        rh = fit_range(cfg_shadow[ipsa_pkg::REG_RATE_PAIR][15:8], BYTE_MAX);
        rw = fit_range(cfg_shadow[ipsa_pkg::REG_RATE_PAIR][7:0], BYTE_MAX);
        b  = longint'(beat.batch);
        if (b >= MAX_BATCH)
            b = MAX_BATCH - 1;
        row = longint'(beat.kernel_row) * rh - pad_top + longint'(beat.out_row) * sh;
        col = longint'(beat.kernel_col) * rw - pad_left + longint'(beat.out_col) * sw;
        res = '0;
        // only the row and column bounds decide padding, channel is never checked
        if (row < 0 || row >= ih || col < 0 || col >= iw)
        begin
            res.is_padding = 1'b1;
        end
        else
        begin
            idx = ((b * ic + longint'(beat.channel)) * ih + row) * iw + col;
            res.source_index = idx[ipsa_pkg::INDEX_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] reg_mask(input int idx);
        case (idx)
            ipsa_pkg::REG_IN_HEIGHT, ipsa_pkg::REG_IN_WIDTH,
            ipsa_pkg::REG_CHANNELS:                          return 32'h1FFF;
            ipsa_pkg::REG_KERNEL_HEIGHT,
            ipsa_pkg::REG_KERNEL_WIDTH:                      return 32'hFF;
            ipsa_pkg::REG_STRIDE_PAIR,
            ipsa_pkg::REG_RATE_PAIR:                         return 32'hFFFF;
            default:                                         return 32'h3;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic stage_config(input logic [31:0] ih, input logic [31:0] iw,
                                input logic [31:0] ch, input logic [31:0] kh,
                                input logic [31:0] kw, input logic [31:0] stride,
                                input logic [31:0] rate, input logic [31:0] mode);
        pending_cfg[ipsa_pkg::REG_IN_HEIGHT]     = ih;
        pending_cfg[ipsa_pkg::REG_IN_WIDTH]      = iw;
        pending_cfg[ipsa_pkg::REG_CHANNELS]      = ch;
        pending_cfg[ipsa_pkg::REG_KERNEL_HEIGHT] = kh;
        pending_cfg[ipsa_pkg::REG_KERNEL_WIDTH]  = kw;
        pending_cfg[ipsa_pkg::REG_STRIDE_PAIR]   = stride;
        pending_cfg[ipsa_pkg::REG_RATE_PAIR]     = rate;
        pending_cfg[ipsa_pkg::REG_PAD_MODE]      = mode;
    endtask

    task automatic stage_directed_setting(input directed_cfg_e s);
        case (s)
            // odd totals on the width axis so upper and lower split differently
            CFG_SAME_UPPER: stage_config(7, 10, 3, 4, 4, 32'h0202, 32'h0102,
                                         32'(ipsa_pkg::PAD_SAME_UPPER));
            CFG_SAME_LOWER: stage_config(7, 10, 3, 4, 4, 32'h0202, 32'h0102,
                                         32'(ipsa_pkg::PAD_SAME_LOWER));
            CFG_LARGEST:    stage_config(4096, 4096, 4096, 255, 255, 32'hFFFF, 32'hFFFF,
                                         32'(ipsa_pkg::PAD_SAME_UPPER));
            // every size zero, read as one, and the unused pad code
            CFG_ZEROS:      stage_config(0, 0, 0, 0, 0, 0, 0, 32'(PAD_UNUSED));
            // sides and channels beyond the caps saturate
            CFG_OVERSIZED:  stage_config(32'h1FFF, 32'h1FFF, 32'h1FFF, 0, 255, 32'h01FF,
                                         32'hFF01, 32'(ipsa_pkg::PAD_SAME_LOWER));
            default:        stage_config(1, 1, 1, 1, 1, 32'h0101, 32'h0101,
                                         32'(ipsa_pkg::PAD_VALID));
        endcase
    endtask

    task automatic stage_random_setting();
        if ($urandom_range(4) == 0)
            stage_config($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
                         $urandom_range(255), $urandom_range(255), $urandom_range(65535),
                         $urandom_range(65535), $urandom_range(3));
        else
            // mostly small images so that a fair share of beats hits real pixels
            stage_config($urandom_range(1, 48), $urandom_range(1, 48), $urandom_range(1, 16),
                         $urandom_range(1, 5), $urandom_range(1, 5),
                         $urandom_range(1, 4) * 256 + $urandom_range(1, 4),
                         $urandom_range(1, 3) * 256 + $urandom_range(1, 3),
                         $urandom_range(3));
    endtask

    task automatic apb_write(input logic [ipsa_pkg::REG_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_shadow[idx] = value & reg_mask(idx);
        refresh_pads();
        // an idle gap after the access keeps psel from toggling twice in a step
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [ipsa_pkg::REG_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== cfg_shadow[idx])
            flag_mismatch($sformatf("register %0d reads %0h, want %0h",
                                    idx, prdata, cfg_shadow[idx]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write every register, optionally with junk above its width, then read all back
    task automatic apply_config(input bit noisy);
        int          r;
        logic [31:0] w;
        for (r = 0; r < REG_COUNT; r++)
        begin
            w = pending_cfg[r];
            if (noisy)
                w = w | ($urandom & ~reg_mask(r));
            apb_write(r[ipsa_pkg::REG_W-1:0], w);
        end
        for (r = 0; r < REG_COUNT; r++)
            apb_read_check(r[ipsa_pkg::REG_W-1:0]);
    endtask

    // close the item side and let the pipe and the pad derivation settle
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (awaited_addresses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // one item beat, with a random gap ahead of it; valid stays up afterwards
    task automatic send_beat(input ipsa_pkg::item_t beat, input bit typed,
                             input ipsa_pkg::result_t want);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        awaited_addresses.insert(awaited_addresses.size(),
                                 typed ? want : source_address_of(beat));
    endtask

    // mostly indices inside the configured patch and output grid, some anywhere
    function automatic ipsa_pkg::item_t random_beat();
        ipsa_pkg::item_t beat;
        int unsigned     kh, kw, ic, sh, sw, rows, cols;
        kh   = 32'(fit_range(cfg_shadow[ipsa_pkg::REG_KERNEL_HEIGHT], BYTE_MAX));
        kw   = 32'(fit_range(cfg_shadow[ipsa_pkg::REG_KERNEL_WIDTH], BYTE_MAX));
        ic   = 32'(fit_range(cfg_shadow[ipsa_pkg::REG_CHANNELS], MAX_CHANNELS));
        sh   = 32'(fit_range(cfg_shadow[ipsa_pkg::REG_STRIDE_PAIR][15:8], BYTE_MAX));
        sw   = 32'(fit_range(cfg_shadow[ipsa_pkg::REG_STRIDE_PAIR][7:0], BYTE_MAX));
        rows = 32'((fit_range(cfg_shadow[ipsa_pkg::REG_IN_HEIGHT], MAX_SIDE) + sh - 1) / sh);
        cols = 32'((fit_range(cfg_shadow[ipsa_pkg::REG_IN_WIDTH], MAX_SIDE) + sw - 1) / sw);
        beat.batch = 8'($urandom_range(255));
        if ($urandom_range(99) < 85)
        begin
            beat.kernel_row = 8'($urandom_range(kh - 1));
            beat.kernel_col = 8'($urandom_range(kw - 1));
            beat.channel    = 12'($urandom_range(ic - 1));
            beat.out_row    = 12'($urandom_range(rows - 1));
            beat.out_col    = 12'($urandom_range(cols - 1));
        end
        else
        begin
            beat.kernel_row = 8'($urandom_range(255));
            beat.kernel_col = 8'($urandom_range(255));
            beat.channel    = 12'($urandom_range(4095));
            beat.out_row    = 12'($urandom_range(4095));
            beat.out_col    = 12'($urandom_range(4095));
        end
        return beat;
    endfunction

    task automatic add_row(input directed_cfg_e s, input int b,
                           input int kr, input int kc,
                           input int ch, input int orow,
                           input int ocol, input int typed,
                           input longint idx, input int pad);
        directed_row_t entry;
        entry.setting               = s;
        entry.beat.batch            = 8'(b);
        entry.beat.kernel_row       = 8'(kr);
        entry.beat.kernel_col       = 8'(kc);
        entry.beat.channel          = 12'(ch);
        entry.beat.out_row          = 12'(orow);
        entry.beat.out_col          = 12'(ocol);
        entry.typed                 = 1'(typed);
        entry.want.source_index     = ipsa_pkg::INDEX_W'(idx);
        entry.want.is_padding       = 1'(pad);
        directed_q.insert(directed_q.size(), entry);
    endtask

    // directed table: after reset the image is one pixel, so index = batch + channel
    task automatic build_directed_table();
        //      setting         batch  krow  kcol  chan     orow     ocol  typed idx   pad
        add_row(CFG_RESET,      0,     0,    0,    0,       0,       0,    1,    0,    0);
        add_row(CFG_RESET,      255,   0,    0,    4095,    0,       0,    1,    4350, 0);
        add_row(CFG_RESET,      'h55,  0,    0,    'hAAA,   0,       0,    1,    2815, 0);
        add_row(CFG_RESET,      'hAA,  0,    0,    'h555,   0,       0,    1,    1535, 0);
        add_row(CFG_RESET,      0,     1,    0,    0,       0,       0,    1,    0,    1);
        add_row(CFG_RESET,      0,     0,    254,  0,       0,       0,    1,    0,    1);
        add_row(CFG_RESET,      0,     0,    0,    0,       4095,    0,    1,    0,    1);
        add_row(CFG_RESET,      0,     0,    0,    0,       0,       1,    1,    0,    1);
        add_row(CFG_RESET,      255,   254,  254,  4095,    4095,    4095, 1,    0,    1);
        // same modes: top-left corner falls in the pad, channel and kernel row past count
        add_row(CFG_SAME_UPPER, 0,     0,    0,    0,       0,       0,    0,    0,    0);
        add_row(CFG_SAME_UPPER, 3,     2,    3,    2,       3,       4,    0,    0,    0);
        add_row(CFG_SAME_UPPER, 1,     1,    1,    1,       1,       1,    0,    0,    0);
        add_row(CFG_SAME_UPPER, 2,     2,    3,    5,       3,       8,    0,    0,    0);
        add_row(CFG_SAME_UPPER, 0,     7,    0,    0,       0,       0,    0,    0,    0);
        add_row(CFG_SAME_LOWER, 0,     0,    0,    0,       0,       0,    0,    0,    0);
        add_row(CFG_SAME_LOWER, 1,     1,    1,    1,       1,       1,    0,    0,    0);
        add_row(CFG_SAME_LOWER, 3,     2,    3,    2,       3,       4,    0,    0,    0);
        // largest geometry: deepest index just inside the image, and far outside it
        add_row(CFG_LARGEST,    255,   0,    0,    4095,    127,     128,  0,    0,    0);
        add_row(CFG_LARGEST,    255,   15,   15,   4095,    128,     128,  0,    0,    0);
        add_row(CFG_LARGEST,    255,   254,  254,  4095,    4095,    4095, 0,    0,    0);
        add_row(CFG_LARGEST,    0,     1,    1,    0,       15,      15,   0,    0,    0);
        add_row(CFG_ZEROS,      0,     0,    0,    0,       0,       0,    0,    0,    0);
        add_row(CFG_ZEROS,      7,     0,    0,    9,       0,       0,    0,    0,    0);
        add_row(CFG_ZEROS,      0,     1,    0,    0,       0,       0,    0,    0,    0);
        add_row(CFG_OVERSIZED,  255,   0,    0,    4095,    4095,    4095, 0,    0,    0);
        add_row(CFG_OVERSIZED,  1,     0,    0,    1,       100,     3000, 0,    0,    0);
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure, in-order compare
    // ------------------------------------------------------------------

    always @(posedge clk)
        result_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin : check_results
        ipsa_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_addresses.size() == 0)
            begin
                flag_mismatch($sformatf("result beat %0d with nothing outstanding",
                                        results_seen));
            end
            else
            begin
                want = awaited_addresses.pop_front();
                if (result.is_padding !== want.is_padding
                    || result.source_index !== want.source_index)
                    flag_mismatch($sformatf("result beat %0d: index %0h pad %0b, want %0h pad %0b",
                                            results_seen, result.source_index,
                                            result.is_padding, want.source_index,
                                            want.is_padding));
            end
            results_seen++;
        end
    end

    // watchdog: any beat on either stream counts as progress
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[image_patch_source_address_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : run
        int            r;
        int            p;
        int            k;
        directed_cfg_e current;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        // shadow starts at the documented reset values
        stage_directed_setting(CFG_RESET);
        for (r = 0; r < REG_COUNT; r++)
            cfg_shadow[r] = pending_cfg[r];
        refresh_pads();
        build_directed_table();

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, switching register sets only with the pipe empty
        current = CFG_RESET;
        for (r = 0; r < directed_q.size(); r++)
        begin
            if (directed_q[r].setting != current)
            begin
                wait_idle();
                current = directed_q[r].setting;
                stage_directed_setting(current);
                apply_config(1'b0);
            end
            send_beat(directed_q[r].beat, directed_q[r].typed, directed_q[r].want);
        end

        // random phases, one with no idling on either side
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            steady = 1'b0;
            stage_random_setting();
            apply_config(1'($urandom_range(1)));
            steady = (p == QUIET_PHASE);
            for (k = 0; k < BEATS_PER_PHASE; k++)
                send_beat(random_beat(), 1'b0, '0);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("[image_patch_source_address_unit] OK");
        else
            $display("[image_patch_source_address_unit] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ipsa_pkg.sv
hw/rtl/ipsa_pad_calc.sv
hw/rtl/image_patch_source_address_unit.sv
hw/rtl/ipsa_checker.sv
sim/image_patch_source_address_unit_test.sv
